[rtl/prrf_pkg.sv]
// Types and constants shared by the packet rule range filter modules.
package prrf_pkg;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    localparam logic [1:0] STATUS_DONE        = 2'd0;
    localparam logic [1:0] STATUS_FULL        = 2'd1;
    localparam logic [1:0] STATUS_EMPTY_RANGE = 2'd2;

    typedef struct packed {
        logic        mode;
        logic        direction;
        logic        protocol;
        logic [15:0] port_first;
        logic [15:0] port_last;
        logic [31:0] ip_first;
        logic [31:0] ip_last;
    } pkt_in_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] status;
    } pkt_out_t;

    typedef struct packed {
        logic        direction;
        logic        protocol;
        logic [15:0] port_low;
        logic [15:0] port_high;
        logic [31:0] ip_low;
        logic [31:0] ip_high;
    } rule_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_WAIT
    } state_t;

endpackage

[rtl/prrf_rule_mem.sv]
// Rule storage: one write port, one read port with registered read data.
module prrf_rule_mem
    import prrf_pkg::*;
#(
    parameter int RULE_SLOTS = 64
)
(
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [(RULE_SLOTS > 1 ? $clog2(RULE_SLOTS) : 1)-1:0] wr_addr,
    input  rule_t                                         wr_rule,
    input  logic                                          rd_en,
    input  logic [(RULE_SLOTS > 1 ? $clog2(RULE_SLOTS) : 1)-1:0] rd_addr,
    output rule_t                                         rd_rule
);

    rule_t rules_mem [RULE_SLOTS];
    rule_t rd_rule_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rules_mem[wr_addr] <= wr_rule;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_rule_reg <= rules_mem[rd_addr];
        end
    end

    assign rd_rule = rd_rule_reg;

endmodule

[rtl/prrf_match.sv]
// Shared compare unit: does one rule cover a direction, protocol, port and address.
module prrf_match
    import prrf_pkg::*;
(
    input  rule_t       rule,
    input  logic        direction,
    input  logic        protocol,
    input  logic [15:0] port,
    input  logic [31:0] ip,
    output logic        hit
);

    logic kind_eq;
    logic port_in;
    logic ip_in;

    assign kind_eq = (rule.direction == direction) && (rule.protocol == protocol);
    assign port_in = (port >= rule.port_low) && (port <= rule.port_high);
    assign ip_in   = (ip >= rule.ip_low) && (ip <= rule.ip_high);
    assign hit     = kind_eq && port_in && ip_in;

endmodule

[rtl/packet_rule_range_filter.sv]
// Top level: sequencer that adds rules and scans the rule table for packet checks.
// Each item either adds a rule or checks a packet, and yields one result item.
// An add steps through accept, ST_ADD, in which the shared compare unit tests the
// ranges and, if both are ordered and the table is not full, the rule is written at
// the next free slot, and ST_WAIT, which hands the result to the output register. A
// check scans the stored rules: the scan reads one rule per cycle through
// the rule memory's single registered read port and feeds it to the shared compare
// unit, stopping at the first hit. With an empty table a check skips the scan.
// The input is taken only while the sequencer is idle; the output register lets a
// finished result wait for the consumer while the next item is accepted.
module packet_rule_range_filter
    import prrf_pkg::*;
#(
    parameter int RULE_SLOTS = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pkt_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pkt_out_t out_data
);

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_reg, pend_next;
    pkt_in_t          item_reg, item_next;
    logic             res_acc_reg, res_acc_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             out_valid_reg, out_valid_next;
    pkt_out_t         out_data_reg, out_data_next;

    rule_t            item_rule;
    rule_t            mem_rule;
    rule_t            unit_rule;
    logic             hit;
    logic             wr_en;
    logic             rd_en;
    logic             more;
    logic             out_free;

    assign item_rule = '{direction: item_reg.direction,
                         protocol:  item_reg.protocol,
                         port_low:  item_reg.port_first,
                         port_high: item_reg.port_last,
                         ip_low:    item_reg.ip_first,
                         ip_high:   item_reg.ip_last};

    // On an add, the item as a rule covers its own low ends only if both ranges are ordered
    assign unit_rule = (state_reg == ST_ADD) ? item_rule : mem_rule;

    prrf_match u_match (
        .rule      (unit_rule),
        .direction (item_reg.direction),
        .protocol  (item_reg.protocol),
        .port      (item_reg.port_first),
        .ip        (item_reg.ip_first),
        .hit       (hit)
    );

    prrf_rule_mem #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_rule_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_rule (item_rule),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_rule (mem_rule)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign more      = (scan_idx_reg != count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        res_acc_reg    <= res_acc_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        item_next       = item_reg;
        res_acc_next    = res_acc_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next       = in_data;
                    res_acc_next    = 1'b0;
                    res_status_next = STATUS_DONE;
                    scan_idx_next   = '0;
                    pend_next       = 1'b0;
                    if (in_data.mode == MODE_ADD)
                    begin
                        state_next = ST_ADD;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_ADD:
            begin
                res_acc_next = 1'b0;
                if (!hit)
                begin
                    res_status_next = STATUS_EMPTY_RANGE;
                end
                else if (count_reg == CNT_W'(RULE_SLOTS))
                begin
                    res_status_next = STATUS_FULL;
                end
                else
                begin
                    res_status_next = STATUS_DONE;
                    wr_en           = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                end
                state_next = ST_WAIT;
            end

            ST_SCAN:
            begin
                res_status_next = STATUS_DONE;
                // Compare the rule read last cycle while the next one is fetched
                if (pend_reg && hit)
                begin
                    res_acc_next = 1'b1;
                    pend_next    = 1'b0;
                    state_next   = ST_WAIT;
                end
                else if (!more)
                begin
                    res_acc_next = 1'b0;
                    pend_next    = 1'b0;
                    state_next   = ST_WAIT;
                end
                else
                begin
                    rd_en         = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                end
            end

            ST_WAIT:
            begin
                if (out_free)
                begin
                    out_data_next  = '{accepted: res_acc_reg, status: res_status_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RULE_SLOTS))
        else $error("rule count exceeds table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("rule count changed by other than one");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (scan_idx_reg < count_reg))
        else $error("scan read beyond stored rules");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.accepted) |-> (out_data.status == STATUS_DONE))
        else $error("accepted result carries a non-done status");

endmodule

[sim/packet_rule_range_filter_tb.sv]
// Self-checking testbench for the packet rule range filter: rule adds and packet checks.
`timescale 1ns / 100ps

module packet_rule_range_filter_tb;
    import prrf_pkg::*;

    localparam int RULE_SLOTS   = 64;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE_CYCLES = RULE_SLOTS + 16;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int REPORT_MAX   = 10;

    // Rule table copy and the queue of verdicts still owed by the block.
    class acl_table;
        rule_t    rules[RULE_SLOTS];
        int       rule_count = 0;
        pkt_out_t verdict_q[$];
        int       bad_count = 0;
        int       items_seen = 0;
        int       stored = 0;
        int       refused_full = 0;
        int       refused_range = 0;
        int       checks = 0;
        int       hits = 0;

        function void note_item(pkt_in_t item);
            pkt_out_t v;
            v.accepted = 1'b0;
            v.status   = STATUS_DONE;
            items_seen++;
            if (item.mode == MODE_ADD)
            begin
                if (item.port_first > item.port_last || item.ip_first > item.ip_last)
                begin
                    v.status = STATUS_EMPTY_RANGE;
                    refused_range++;
                end
                else if (rule_count >= RULE_SLOTS)
                begin
                    v.status = STATUS_FULL;
                    refused_full++;
                end
                else
                begin
                    rules[rule_count] = '{direction: item.direction, protocol: item.protocol,
                                          port_low: item.port_first, port_high: item.port_last,
                                          ip_low: item.ip_first, ip_high: item.ip_last};
                    rule_count++;
                    stored++;
                end
            end
            else
            begin
                checks++;
                for (int i = 0; i < rule_count; i++)
                begin
                    if (rules[i].direction == item.direction &&
                        rules[i].protocol == item.protocol &&
                        item.port_first >= rules[i].port_low &&
                        item.port_first <= rules[i].port_high &&
                        item.ip_first >= rules[i].ip_low &&
                        item.ip_first <= rules[i].ip_high)
                        v.accepted = 1'b1;
                end
                if (v.accepted)
                    hits++;
            end
            verdict_q.push_back(v);
        endfunction

        function void flag(string what);
            bad_count++;
            if (bad_count <= REPORT_MAX)
                $display("ERROR at %0t: %s", $realtime, what);
        endfunction

        function void check_verdict(pkt_out_t got);
            pkt_out_t want;
            if (verdict_q.size() == 0)
            begin
                flag($sformatf("unexpected result accepted=%0b status=%0d",
                               got.accepted, got.status));
                return;
            end
            want = verdict_q.pop_front();
            if (got.accepted !== want.accepted || got.status !== want.status)
                flag($sformatf("expected accepted=%0b status=%0d, got accepted=%0b status=%0d",
                               want.accepted, want.status, got.accepted, got.status));
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    pkt_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    pkt_out_t out_data;

    acl_table table_copy = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_serial    = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    packet_rule_range_filter #(.RULE_SLOTS(RULE_SLOTS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, table_copy.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (hold_serial != hold_seen)
        begin
            hold_seen = hold_serial;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            table_copy.check_verdict(out_data);
    end

    function automatic longint unsigned pick_between(longint unsigned lo, longint unsigned hi);
        return lo + ({$urandom, $urandom} % (hi - lo + 1));
    endfunction

    function automatic pkt_in_t rule_item(logic dir, logic proto, logic [15:0] plo,
                                          logic [15:0] phi, logic [31:0] ilo, logic [31:0] ihi);
        pkt_in_t item;
        item = '{mode: MODE_ADD, direction: dir, protocol: proto, port_first: plo,
                 port_last: phi, ip_first: ilo, ip_last: ihi};
        return item;
    endfunction

    // Ignored fields of a check carry random bits.
    function automatic pkt_in_t check_item(logic dir, logic proto, logic [15:0] port,
                                           logic [31:0] ip);
        pkt_in_t item;
        item = '{mode: MODE_CHECK, direction: dir, protocol: proto, port_first: port,
                 port_last: 16'($urandom), ip_first: ip, ip_last: 32'($urandom)};
        return item;
    endfunction

    function automatic pkt_in_t random_rule(bit inverted);
        logic [15:0] plo, phi, pa, pb;
        logic [31:0] ilo, ihi, ia, ib;
        int          kind;
        kind = $urandom_range(9);
        plo = 16'($urandom);
        ilo = $urandom;
        if (kind <= 5)
        begin
            phi = 16'(pick_between(plo, (int'(plo) + 15 > 65535) ? 65535 : plo + 15));
            ihi = 32'(pick_between(ilo, (longint'(ilo) + 255 > 32'hFFFFFFFF) ?
                                        32'hFFFFFFFF : longint'(ilo) + 255));
        end
        else if (kind <= 8)
        begin
            phi = 16'(pick_between(plo, (int'(plo) + 4095 > 65535) ? 65535 : plo + 4095));
            ihi = 32'(pick_between(ilo, (longint'(ilo) + (1 << 20) > 32'hFFFFFFFF) ?
                                        32'hFFFFFFFF : longint'(ilo) + (1 << 20)));
        end
        else
        begin
            plo = 16'($urandom_range(255));
            phi = 16'(pick_between(plo, 65535));
            ilo = 32'($urandom_range(65535));
            ihi = 32'(pick_between(ilo, 32'hFFFFFFFF));
        end
        if (inverted)
        begin
            pa = 16'($urandom);
            pb = 16'($urandom);
            ia = $urandom;
            ib = $urandom;
            if (pa == pb)
                pb = pa ^ 16'h0001;
            if (ia == ib)
                ib = ia ^ 32'h1;
            case ($urandom_range(2))
                0:
                begin
                    plo = (pa > pb) ? pa : pb;
                    phi = (pa > pb) ? pb : pa;
                end
                1:
                begin
                    ilo = (ia > ib) ? ia : ib;
                    ihi = (ia > ib) ? ib : ia;
                end
                default:
                begin
                    plo = (pa > pb) ? pa : pb; phi = (pa > pb) ? pb : pa;
                    ilo = (ia > ib) ? ia : ib; ihi = (ia > ib) ? ib : ia;
                end
            endcase
        end
        return rule_item(1'($urandom_range(1)), 1'($urandom_range(1)), plo, phi, ilo, ihi);
    endfunction

    // Aim most checks at a stored rule: inside, on its edges, or just outside.
    function automatic pkt_in_t random_check();
        rule_t       r;
        logic        dir, proto;
        logic [15:0] port;
        logic [31:0] ip;
        if (table_copy.rule_count == 0 || $urandom_range(99) < 20)
            return check_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                              16'($urandom), $urandom);
        r = table_copy.rules[$urandom_range(table_copy.rule_count - 1)];
        dir = r.direction;
        proto = r.protocol;
        if ($urandom_range(99) < 15)
        begin
            dir = 1'($urandom_range(1));
            proto = 1'($urandom_range(1));
        end
        case ($urandom_range(5))
            0: port = r.port_low;
            1: port = r.port_high;
            2: port = r.port_low - 16'd1;
            3: port = r.port_high + 16'd1;
            default: port = 16'(pick_between(r.port_low, r.port_high));
        endcase
        case ($urandom_range(5))
            0: ip = r.ip_low;
            1: ip = r.ip_high;
            2: ip = r.ip_low - 32'd1;
            3: ip = r.ip_high + 32'd1;
            default: ip = 32'(pick_between(r.ip_low, r.ip_high));
        endcase
        return check_item(dir, proto, port, ip);
    endfunction

    function automatic pkt_in_t random_item();
        int add_pct;
        add_pct = (table_copy.rule_count < RULE_SLOTS) ? 22 : 12;
        if ($urandom_range(99) < add_pct)
            return random_rule($urandom_range(99) < 12);
        return random_check();
    endfunction

    task automatic send_item(input pkt_in_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        table_copy.note_item(item);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (table_copy.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_item(random_item());
        drain();
    endtask

    initial
    begin
        pkt_in_t directed_q[$];

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table first, then inverted ranges, full-span and single-point rules.
        directed_q.push_back(check_item(1'b0, 1'b0, 16'h0000, 32'h0000_0000));
        directed_q.push_back(check_item(1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
        directed_q.push_back(rule_item(1'b0, 1'b0, 16'h0001, 16'h0000, 32'h0, 32'hFFFF_FFFF));
        directed_q.push_back(rule_item(1'b1, 1'b0, 16'h0000, 16'hFFFF, 32'h2, 32'h1));
        directed_q.push_back(rule_item(1'b1, 1'b1, 16'h0000, 16'hFFFF, 32'h0, 32'hFFFF_FFFF));
        directed_q.push_back(check_item(1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
        directed_q.push_back(check_item(1'b1, 1'b1, 16'h0000, 32'h0000_0000));
        directed_q.push_back(check_item(1'b0, 1'b1, 16'h1234, 32'h8000_0000));
        directed_q.push_back(check_item(1'b1, 1'b0, 16'h1234, 32'h8000_0000));
        directed_q.push_back(rule_item(1'b0, 1'b0, 16'd80, 16'd80, 32'h0A00_0001, 32'h0A00_0001));
        directed_q.push_back(check_item(1'b0, 1'b0, 16'd80, 32'h0A00_0001));
        directed_q.push_back(check_item(1'b0, 1'b0, 16'd79, 32'h0A00_0001));
        directed_q.push_back(check_item(1'b0, 1'b0, 16'd81, 32'h0A00_0001));
        directed_q.push_back(check_item(1'b0, 1'b0, 16'd80, 32'h0A00_0000));
        directed_q.push_back(check_item(1'b0, 1'b0, 16'd80, 32'h0A00_0002));
        directed_q.push_back(rule_item(1'b0, 1'b1, 16'h0000, 16'h0000, 32'h0, 32'h0));
        directed_q.push_back(check_item(1'b0, 1'b1, 16'h0000, 32'h0000_0000));
        directed_q.push_back(check_item(1'b0, 1'b1, 16'h0001, 32'h0000_0000));
        directed_q.push_back(rule_item(1'b1, 1'b0, 16'hFFFF, 16'hFFFF,
                                       32'hFFFF_FF00, 32'hFFFF_FFFF));
        directed_q.push_back(check_item(1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF));
        directed_q.push_back(check_item(1'b1, 1'b0, 16'hFFFE, 32'hFFFF_FFFF));
        directed_q.push_back(rule_item(1'b0, 1'b0, 16'h8000, 16'hFFFF,
                                       32'h8000_0000, 32'hFFFF_FFFF));
        directed_q.push_back(check_item(1'b0, 1'b0, 16'h8000, 32'h8000_0000));
        foreach (directed_q[i])
            send_item(directed_q[i]);
        drain();

        // Long receiver hold-off while the sender keeps offering items.
        hold_serial = hold_serial + 1;
        run_random(250, 0, 0);
        run_random(250, 68, 0);
        run_random(250, 0, 68);
        run_random(275, 27, 27);

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d rules stored, %0d refused on a full table, %0d inverted",
                 table_copy.items_seen, table_copy.stored, table_copy.refused_full,
                 table_copy.refused_range);
        $display("Ran %0d packet checks, %0d of them matched a rule, in %0d cycles",
                 table_copy.checks, table_copy.hits, cycle_count);
        if (table_copy.bad_count == 0 && table_copy.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/prrf_pkg.sv
rtl/prrf_rule_mem.sv
rtl/prrf_match.sv
rtl/packet_rule_range_filter.sv
sim/packet_rule_range_filter_tb.sv
